@@ rtl/gbd_pkg.sv @@
// Shared types and constants of the gamma-aware box downsampler.
`default_nettype none

package gbd_pkg;

    localparam int MAX_DEST_WIDTH = 1024;
    localparam int MAX_FACTOR     = 16;

    localparam int COL_AW = (MAX_DEST_WIDTH > 1) ? $clog2(MAX_DEST_WIDTH) : 1;
    localparam int PH_W   = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;

    localparam logic [2:0] OP_LOAD_COLOUR_FWD = 3'd0;
    localparam logic [2:0] OP_LOAD_ALPHA_FWD  = 3'd1;
    localparam logic [2:0] OP_LOAD_COLOUR_BWD = 3'd2;
    localparam logic [2:0] OP_LOAD_ALPHA_BWD  = 3'd3;
    localparam logic [2:0] OP_PIXEL           = 3'd4;

    localparam logic [1:0] CFG_FACTOR       = 2'd0;
    localparam logic [1:0] CFG_DEST_WIDTH   = 2'd1;
    localparam logic [1:0] CFG_DEST_HEIGHT  = 2'd2;
    localparam logic [1:0] CFG_SOURCE_WIDTH = 2'd3;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] table_index;
        logic [15:0] table_value;
        logic [7:0]  pixel_blue;
        logic [7:0]  pixel_green;
        logic [7:0]  pixel_red;
        logic [7:0]  pixel_alpha;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_blue;
        logic [7:0]  out_green;
        logic [7:0]  out_red;
        logic [7:0]  out_alpha;
        logic [9:0]  out_column;
        logic [15:0] out_row;
        logic        row_end;
        logic        frame_end;
    } out_item_t;

endpackage

`default_nettype wire

@@ rtl/gamma_box_downsampler_top.sv @@
// Top level of the gamma-aware box downsampler: counters, table memories and line buffer.
//
// The req channel carries one item per handshake: a table load or a source pixel in
// raster order. The rsp channel carries one destination pixel each time the last
// source pixel of a factor-by-factor block arrives. Configuration is written through
// cfg_we, cfg_index and cfg_data while the block is idle; any write restarts the frame.
// The design is a four-stage pipeline around its memories: forward table read, pixel
// sum, line buffer read-modify-write with backward table read, and the output register.
// It accepts one item per cycle while the receiver does not stall; a result is valid
// once its item has passed s1_reg, s2_reg and s3_reg into the output register. The line
// buffer is read one stage before it is written, with no forwarding of pending writes.
// When the receiver stalls, the whole pipeline holds and req_ready drops, while a new
// item is still taken in any cycle where the output register is empty or drained.
// Reset sets the configuration and counter registers to defaults and empties the
// pipeline; the table memories and line buffer hold no defined contents until written.
`default_nettype none

module gamma_box_downsampler_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                req_valid,
    output logic                req_ready,
    input  gbd_pkg::in_item_t   req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output gbd_pkg::out_item_t  rsp
);

    typedef struct packed {
        logic                       use_px;
        logic                       first;
        logic                       last;
        logic                       rig0;
        logic                       emit;
        logic [gbd_pkg::COL_AW-1:0] blk;
        logic [15:0]                row;
        logic                       row_end;
        logic                       frame_end;
        logic                       ld_colour;
        logic                       ld_alpha;
        logic [15:0]                idx;
        logic [7:0]                 val;
    } pipe_t;

    function automatic logic [63:0] add_lanes(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        for (int k = 0; k < 4; k++)
        begin
            r[16*k +: 16] = a[16*k +: 16] + b[16*k +: 16];
        end
        return r;
    endfunction

    logic [4:0]  factor_reg;
    logic [10:0] dest_width_reg;
    logic [15:0] dest_height_reg;
    logic [15:0] source_width_reg;

    logic [15:0]              col_reg, col_next, col_inc;
    logic [15:0]              blk_reg, blk_next;
    logic [gbd_pkg::PH_W-1:0] ph_reg, ph_next;
    logic [gbd_pkg::PH_W-1:0] rig_reg, rig_next;
    logic [15:0]              drow_reg, drow_next;

    logic [4:0]               f;
    logic [gbd_pkg::PH_W-1:0] fm1;
    logic [10:0]              dw;
    logic                     adv, accept, active, in_blk, pix_step;
    logic                     fwd_colour_we, fwd_alpha_we;

    pipe_t ctrl0, s1_reg, s2_reg, s3_reg;

    logic [15:0] fwd_b_reg, fwd_g_reg, fwd_r_reg, fwd_a_reg;
    logic [63:0] v, psum_reg, psum_new, psum2_reg, colrd_reg, cs;
    logic [7:0]  bwd_b_reg, bwd_g_reg, bwd_r_reg, bwd_a_reg;

    logic                rsp_valid_reg;
    gbd_pkg::out_item_t  rsp_reg;

    logic [15:0] colour_fwd0_mem [256];
    logic [15:0] colour_fwd1_mem [256];
    logic [15:0] colour_fwd2_mem [256];
    logic [15:0] alpha_fwd_mem   [256];
    logic [7:0]  colour_bwd0_mem [65536];
    logic [7:0]  colour_bwd1_mem [65536];
    logic [7:0]  colour_bwd2_mem [65536];
    logic [7:0]  alpha_bwd_mem   [65536];
    logic [63:0] colsum_mem      [gbd_pkg::MAX_DEST_WIDTH];

    assign adv       = !rsp_valid_reg || rsp_ready;
    assign req_ready = adv;
    assign accept    = req_valid && adv;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        if (factor_reg == 5'd0)
            f = 5'd1;
        else if (32'(factor_reg) > 32'(gbd_pkg::MAX_FACTOR))
            f = 5'(gbd_pkg::MAX_FACTOR);
        else
            f = factor_reg;
        fm1 = gbd_pkg::PH_W'(f - 5'd1);
        if (32'(dest_width_reg) > 32'(gbd_pkg::MAX_DEST_WIDTH))
            dw = 11'(gbd_pkg::MAX_DEST_WIDTH);
        else
            dw = dest_width_reg;
    end

    assign active = (req.operation == gbd_pkg::OP_PIXEL) && (dw != 11'd0)
                    && (dest_height_reg != 16'd0) && (drow_reg < dest_height_reg);
    assign in_blk   = blk_reg < 16'(dw);
    assign pix_step = accept && active;

    assign fwd_colour_we = accept && (req.operation == gbd_pkg::OP_LOAD_COLOUR_FWD)
                           && (req.table_index[15:8] == 8'd0);
    assign fwd_alpha_we  = accept && (req.operation == gbd_pkg::OP_LOAD_ALPHA_FWD)
                           && (req.table_index[15:8] == 8'd0);

    always_comb
    begin
        col_inc   = col_reg + 16'd1;
        col_next  = col_inc;
        blk_next  = blk_reg;
        ph_next   = ph_reg;
        rig_next  = rig_reg;
        drow_next = drow_reg;
        if (col_inc == source_width_reg)
        begin
            col_next = '0;
            blk_next = '0;
            ph_next  = '0;
            if (rig_reg == fm1)
            begin
                rig_next  = '0;
                drow_next = drow_reg + 16'd1;
            end
            else
            begin
                rig_next = rig_reg + gbd_pkg::PH_W'(1);
            end
        end
        else if (col_inc == 16'd0)
        begin
            blk_next = '0;
            ph_next  = '0;
        end
        else if (ph_reg == fm1)
        begin
            ph_next  = '0;
            blk_next = blk_reg + 16'd1;
        end
        else
        begin
            ph_next = ph_reg + gbd_pkg::PH_W'(1);
        end
    end

    always_comb
    begin
        ctrl0           = '0;
        ctrl0.use_px    = pix_step && in_blk;
        ctrl0.first     = ph_reg == '0;
        ctrl0.last      = ph_reg == fm1;
        ctrl0.rig0      = rig_reg == '0;
        ctrl0.emit      = pix_step && in_blk && (ph_reg == fm1) && (rig_reg == fm1);
        ctrl0.blk       = blk_reg[gbd_pkg::COL_AW-1:0];
        ctrl0.row       = drow_reg;
        ctrl0.row_end   = blk_reg == 16'(dw - 11'd1);
        ctrl0.frame_end = (blk_reg == 16'(dw - 11'd1))
                          && (drow_reg == dest_height_reg - 16'd1);
        ctrl0.ld_colour = accept && (req.operation == gbd_pkg::OP_LOAD_COLOUR_BWD);
        ctrl0.ld_alpha  = accept && (req.operation == gbd_pkg::OP_LOAD_ALPHA_BWD);
        ctrl0.idx       = req.table_index;
        ctrl0.val       = req.table_value[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg       <= 5'd1;
            dest_width_reg   <= 11'd1;
            dest_height_reg  <= 16'd1;
            source_width_reg <= 16'd1;
            col_reg          <= '0;
            blk_reg          <= '0;
            ph_reg           <= '0;
            rig_reg          <= '0;
            drow_reg         <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gbd_pkg::CFG_FACTOR:       factor_reg       <= cfg_data[4:0];
                gbd_pkg::CFG_DEST_WIDTH:   dest_width_reg   <= cfg_data[10:0];
                gbd_pkg::CFG_DEST_HEIGHT:  dest_height_reg  <= cfg_data;
                gbd_pkg::CFG_SOURCE_WIDTH: source_width_reg <= cfg_data;
                default:                   factor_reg       <= factor_reg;
            endcase
            col_reg  <= '0;
            blk_reg  <= '0;
            ph_reg   <= '0;
            rig_reg  <= '0;
            drow_reg <= '0;
        end
        else if (pix_step)
        begin
            col_reg  <= col_next;
            blk_reg  <= blk_next;
            ph_reg   <= ph_next;
            rig_reg  <= rig_next;
            drow_reg <= drow_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            s2_reg        <= '0;
            s3_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_reg        <= ctrl0;
            s2_reg        <= s1_reg;
            s3_reg        <= s2_reg;
            rsp_valid_reg <= s3_reg.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fwd_colour_we)
        begin
            colour_fwd0_mem[req.table_index[7:0]] <= req.table_value;
            colour_fwd1_mem[req.table_index[7:0]] <= req.table_value;
            colour_fwd2_mem[req.table_index[7:0]] <= req.table_value;
        end
        if (fwd_alpha_we)
            alpha_fwd_mem[req.table_index[7:0]] <= req.table_value;
        if (adv)
        begin
            fwd_b_reg <= colour_fwd0_mem[req.pixel_blue];
            fwd_g_reg <= colour_fwd1_mem[req.pixel_green];
            fwd_r_reg <= colour_fwd2_mem[req.pixel_red];
            fwd_a_reg <= alpha_fwd_mem[req.pixel_alpha];
        end
    end

    assign v        = {fwd_a_reg, fwd_r_reg, fwd_g_reg, fwd_b_reg};
    assign psum_new = s1_reg.first ? v : add_lanes(psum_reg, v);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (s1_reg.use_px)
                psum_reg <= psum_new;
            psum2_reg <= psum_new;
        end
    end

    assign cs = s2_reg.rig0 ? psum2_reg : add_lanes(colrd_reg, psum2_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (s2_reg.use_px && s2_reg.last)
                colsum_mem[s2_reg.blk] <= cs;
            colrd_reg <= colsum_mem[s1_reg.blk];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (s2_reg.ld_colour)
            begin
                colour_bwd0_mem[s2_reg.idx] <= s2_reg.val;
                colour_bwd1_mem[s2_reg.idx] <= s2_reg.val;
                colour_bwd2_mem[s2_reg.idx] <= s2_reg.val;
            end
            if (s2_reg.ld_alpha)
                alpha_bwd_mem[s2_reg.idx] <= s2_reg.val;
            bwd_b_reg <= colour_bwd0_mem[cs[15:0]];
            bwd_g_reg <= colour_bwd1_mem[cs[31:16]];
            bwd_r_reg <= colour_bwd2_mem[cs[47:32]];
            bwd_a_reg <= alpha_bwd_mem[cs[63:48]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s3_reg.emit)
        begin
            rsp_reg.out_blue   <= bwd_b_reg;
            rsp_reg.out_green  <= bwd_g_reg;
            rsp_reg.out_red    <= bwd_r_reg;
            rsp_reg.out_alpha  <= bwd_a_reg;
            rsp_reg.out_column <= 10'(s3_reg.blk);
            rsp_reg.out_row    <= s3_reg.row;
            rsp_reg.row_end    <= s3_reg.row_end;
            rsp_reg.frame_end  <= s3_reg.frame_end;
        end
    end

endmodule

`default_nettype wire

@@ rtl/gbd_checker.sv @@
// Port-level checker for the gamma-aware box downsampler and its bind statement.
`default_nettype none

module gbd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input gbd_pkg::out_item_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("A stalled result item changed or was dropped.");

    a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (!rsp.frame_end || rsp.row_end))
        else $error("Frame end was flagged off the last column of a row.");

    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready == (!rsp_valid || rsp_ready))
        else $error("Input ready does not follow the state of the output register.");

    a_result_needs_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_ready))
        else $error("A result item appeared while the pipeline was held.");

    a_no_ready_without_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid)
        else $error("Input stalled with no result item waiting.");

endmodule

bind gamma_box_downsampler_top gbd_checker u_gbd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire
